// ----- design/fsd_pkg.sv -----
// Shared types, constants and the derandomizer sequence function for the frame synchronizer.
package fsd_pkg;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CNT_W      = 12;

	localparam logic [31:0] SYNC_MARKER_RST = 32'h1ACF_FC1D;
	localparam logic [7:0]  FRAME_BYTES_RST = 8'd120;
	localparam logic [7:0]  LFSR_SEED       = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_MARKER = 8'd0,
		REG_FRAME_BYTES = 8'd1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] sync_marker;
		logic [7:0]  frame_bytes;
	} cfg_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       last_of_frame;
		logic       sync_found;
		logic       sync_inverted;
	} result_t;

	typedef struct packed {
		logic [7:0] pn_byte;
		logic [7:0] next_state;
	} pn_t;

	// Eight LFSR steps: output bit 0, shift right, feed s7^s5^s3^s0 into bit 7.
	function automatic pn_t pn_step(input logic [7:0] seed);
		logic [7:0] st;
		logic [7:0] ob;
		logic       fb;
		pn_t        r;
		st = seed;
		ob = '0;
		for (int k = 0; k < 8; k++) begin
			fb = st[7] ^ st[5] ^ st[3] ^ st[0];
			ob = {ob[6:0], st[0]};
			st = {fb, st[7:1]};
		end
		r.pn_byte    = ob;
		r.next_state = st;
		return r;
	endfunction

endpackage

// ----- design/fsd_in_if.sv -----
// Input bit channel: one received bit per transaction.
interface fsd_in_if;
	logic valid;
	logic ready;
	logic rx_bit;

	modport source (output valid, output rx_bit, input ready);
	modport sink   (input valid, input rx_bit, output ready);
endinterface

// ----- design/fsd_out_if.sv -----
// Result channel: derandomized byte and sync status per transaction.
interface fsd_out_if;
	logic       valid;
	logic       ready;
	logic       byte_valid;
	logic [7:0] data_byte;
	logic       last_of_frame;
	logic       sync_found;
	logic       sync_inverted;

	modport source (output valid, output byte_valid, output data_byte, output last_of_frame,
		output sync_found, output sync_inverted, input ready);
	modport sink   (input valid, input byte_valid, input data_byte, input last_of_frame,
		input sync_found, input sync_inverted, output ready);
endinterface

// ----- design/fsd_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface fsd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fsd_pkg::CFG_IDX_W-1:0]   index;
	logic [fsd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/fsd_cfg_regs.sv -----
// Configuration register file: sync marker and frame length.
module fsd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	fsd_cfg_if.sink       cfg,
	output fsd_pkg::cfg_t cfg_o
);
	import fsd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_o     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_marker <= SYNC_MARKER_RST;
			regs_q.frame_bytes <= FRAME_BYTES_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SYNC_MARKER: regs_q.sync_marker <= cfg.data;
				REG_FRAME_BYTES: regs_q.frame_bytes <= cfg.data[7:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

endmodule

// ----- design/fsd_core.sv -----
// Sync search, lock tracking, byte assembly and derandomization for one bit per step.
module fsd_core #(
	parameter int unsigned MAX_FRAME_BYTES = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fsd_pkg::cfg_t    cfg,
	input  logic             step_en,
	input  logic             rx_bit,
	output fsd_pkg::result_t res,
	output logic             res_valid
);
	import fsd_pkg::*;

	localparam logic [CNT_W-1:0] MAX_BYTES = CNT_W'(MAX_FRAME_BYTES);

	logic [31:0]      window_q;
	logic             locked_q;
	logic             pol_inv_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       lfsr_q;

	logic [31:0]      window_d;
	logic [CNT_W-1:0] cnt_inc;
	logic [7:0]       limit;
	logic [CNT_W-4:0] byte_idx;
	logic             boundary;
	logic             have_byte;
	logic             drop_lock;
	logic             hit_true;
	logic             hit_inv;
	logic             hit;
	pn_t              pn;

	always_comb begin
		window_d  = {window_q[30:0], rx_bit};
		cnt_inc   = cnt_q + 1'b1;
		limit     = ({4'b0, cfg.frame_bytes} > MAX_BYTES) ? MAX_BYTES[7:0] : cfg.frame_bytes;
		byte_idx  = cnt_inc[CNT_W-1:3];
		boundary  = locked_q && (cnt_inc[2:0] == 3'd0);
		have_byte = boundary && (byte_idx <= {1'b0, limit});
		drop_lock = boundary && !(byte_idx <= {1'b0, limit});
		hit_true  = (window_d == cfg.sync_marker);
		hit_inv   = !hit_true && (window_d == ~cfg.sync_marker);
		hit       = hit_true || hit_inv;
		pn        = pn_step(lfsr_q);

		res.byte_valid    = have_byte;
		res.data_byte     = have_byte ? (window_d[7:0] ^ {8{pol_inv_q}} ^ pn.pn_byte) : 8'h00;
		res.last_of_frame = have_byte && (byte_idx == {1'b0, limit});
		res.sync_found    = hit;
		res.sync_inverted = hit_inv;
		res_valid         = have_byte || hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			locked_q  <= 1'b0;
			pol_inv_q <= 1'b0;
			cnt_q     <= '0;
			lfsr_q    <= LFSR_SEED;
		end else if (step_en) begin
			window_q <= window_d;
			if (hit) begin
				// marker restarts the frame, even mid-frame
				locked_q  <= 1'b1;
				pol_inv_q <= hit_inv;
				cnt_q     <= '0;
				lfsr_q    <= LFSR_SEED;
			end else begin
				if (drop_lock)
					locked_q <= 1'b0;
				if (locked_q)
					cnt_q <= cnt_inc;
				if (have_byte)
					lfsr_q <= pn.next_state;
			end
		end
	end

endmodule

// ----- design/frame_sync_derandomizer.sv -----
// Top level of the frame synchronizer and derandomizer: input stage, core and result register.
//
// One received bit enters per din transaction and is shifted into a 32-bit window, oldest bit
// first. A match against the sync_marker register (index 0) or its complement locks the block,
// records the stream polarity and restarts the derandomizer LFSR (x^8 taps 7,5,3,0) at 0xFF.
// While locked, each eighth bit yields one dout transaction carrying the byte, polarity-corrected
// and XORed with the next pseudo-random byte, first received bit in the MSB; the byte numbered
// frame_bytes (index 1, clamped to MAX_FRAME_BYTES) is flagged last_of_frame, and the next byte
// boundary drops lock without output. A bit that completes a marker also produces a dout
// transaction with sync_found set, merged with that bit's byte when both occur. Bits producing
// neither give no transaction. The block accepts one bit every cycle: the whole step (window
// shift, two 32-bit compares, eight LFSR steps) is combinational logic between the input stage
// and the result register, and a result is registered there as its bit leaves the input stage. The
// input keeps flowing while a result waits, until both stages are full and dout is stalled.
// Write configuration only while the block is idle.
module frame_sync_derandomizer #(
	parameter int unsigned MAX_FRAME_BYTES = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	fsd_cfg_if.sink   cfg,
	fsd_in_if.sink    din,
	fsd_out_if.source dout
);
	import fsd_pkg::*;

	cfg_t    cfg_regs;
	result_t core_res;
	logic    core_res_valid;
	logic    advance;

	logic    in_valid_q;
	logic    rx_bit_s1;
	logic    out_valid_q;
	result_t res_q;

	// input stage moves into the core when the result register is free or draining
	assign advance   = in_valid_q && (!out_valid_q || dout.ready);
	assign din.ready = !in_valid_q || advance;

	fsd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_regs)
	);

	fsd_core #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs),
		.step_en   (advance),
		.rx_bit    (rx_bit_s1),
		.res       (core_res),
		.res_valid (core_res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (din.valid && din.ready) begin
			in_valid_q <= 1'b1;
		end else if (advance) begin
			in_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready)
			rx_bit_s1 <= din.rx_bit;
	end

	// result register; a step with no result leaves it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= core_res_valid;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= core_res;
	end

	assign dout.valid         = out_valid_q;
	assign dout.byte_valid    = res_q.byte_valid;
	assign dout.data_byte     = res_q.data_byte;
	assign dout.last_of_frame = res_q.last_of_frame;
	assign dout.sync_found    = res_q.sync_found;
	assign dout.sync_inverted = res_q.sync_inverted;

	// a delivered result always carries a byte or a sync hit
	a_res_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.byte_valid || dout.sync_found))
		else $error("empty result transaction");

	// last flag and inverted flag only ride on their companion flags
	a_flag_deps: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> ((!dout.last_of_frame || dout.byte_valid) &&
			(!dout.sync_inverted || dout.sync_found)))
		else $error("orphan last_of_frame or sync_inverted");

	// a stalled input stage keeps the input blocked
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_q && out_valid_q && !dout.ready) |-> !din.ready)
		else $error("input accepted while both stages full");

	// a core step with a result always lands it in the result register
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && core_res_valid) |=> out_valid_q)
		else $error("core result lost");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the frame synchronizer and derandomizer.
`timescale 1ns / 100ps

module tb_top;
	import fsd_pkg::*;

	localparam int unsigned MAX_FRAME_BYTES = 255;
	// Bits still in the input stage or core when the last result has arrived.
	localparam int unsigned DRAIN_CYCLES    = 8;
	// Cycles with no transaction on any channel before the run is declared hung.
	localparam int unsigned IDLE_LIMIT      = 1000;
	localparam int unsigned WAIT_MAX        = 17;
	localparam logic [7:0]  PN_TAPS         = 8'hA9;   // bits 7, 5, 3, 0
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP  = 8'hFF;

	logic clk;
	logic arst_n;

	fsd_cfg_if cfg_ch ();
	fsd_in_if  bit_ch ();
	fsd_out_if res_ch ();

	frame_sync_derandomizer #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.din   (bit_ch),
		.dout  (res_ch)
	);

	// Shadow copy of the synchronizer: config and tracking state.
	logic [31:0] marker    = SYNC_MARKER_RST;
	logic [7:0]  frame_len = FRAME_BYTES_RST;
	logic [31:0] window    = '0;
	logic        locked    = 1'b0;
	logic        inverted  = 1'b0;
	logic [11:0] bit_cnt   = '0;
	logic [7:0]  lfsr      = LFSR_SEED;

	logic        rx_bit_fifo[$];     // bits waiting for the driver
	result_t     results_due[$];     // predicted results, oldest first
	int unsigned bits_in_flight = 0; // queued or on the bus, not yet accepted
	int unsigned bits_loaded    = 0;
	int unsigned results_seen   = 0;
	int unsigned bits_queued    = 0;
	int unsigned mismatches     = 0;
	int unsigned idle_cycles    = 0;
	int unsigned send_wait;
	int unsigned recv_wait;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Every 4th stretch of 40 transactions runs back to back; otherwise mostly
	// short waits with an occasional long one.
	function automatic int unsigned draw_wait(input int unsigned n);
		if ((n / 40) % 4 == 3)
			return 0;
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, WAIT_MAX) : $urandom_range(0, 1);
	endfunction

	// One bit step of the synchronizer; queues a result when a byte completes
	// and/or the window hits the marker.
	task automatic derandomize_bit(input logic b);
		result_t     res;
		logic [7:0]  pn;
		int unsigned byte_no;
		int unsigned limit_bytes;
		logic        hit;
		res = '0;
		pn  = '0;
		limit_bytes = (frame_len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : frame_len;
		window = {window[30:0], b};
		if (locked) begin
			bit_cnt = bit_cnt + 12'd1;
			if (bit_cnt[2:0] == 3'd0) begin
				byte_no = bit_cnt[11:3];
				if (byte_no <= limit_bytes) begin
					for (int k = 0; k < 8; k++) begin
						pn   = {pn[6:0], lfsr[0]};
						lfsr = {^(lfsr & PN_TAPS), lfsr[7:1]};
					end
					res.byte_valid    = 1'b1;
					res.data_byte     = window[7:0] ^ {8{inverted}} ^ pn;
					res.last_of_frame = (byte_no == limit_bytes);
				end else begin
					// boundary past the last byte: lock drops, nothing out
					locked = 1'b0;
				end
			end
		end
		// marker check runs after the byte step, so a mid-frame hit can share
		// a result with the byte it completes
		hit = (window == marker) || (window == ~marker);
		if (hit) begin
			res.sync_found    = 1'b1;
			res.sync_inverted = (window != marker);
			locked   = 1'b1;
			inverted = res.sync_inverted;
			bit_cnt  = '0;
			lfsr     = LFSR_SEED;
		end
		if (res.byte_valid || hit)
			results_due.push_back(res);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Bit driver: a new bit goes out only when the bus slot is free and the
	// drawn wait has run out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ch.valid  <= 1'b0;
			bit_ch.rx_bit <= 1'b0;
			send_wait     <= 0;
		end else begin
			if (bit_ch.valid && bit_ch.ready) begin
				derandomize_bit(bit_ch.rx_bit);
				bits_in_flight--;
			end
			if (!bit_ch.valid || bit_ch.ready) begin
				if (send_wait != 0) begin
					send_wait    <= send_wait - 1;
					bit_ch.valid <= 1'b0;
				end else if (rx_bit_fifo.size() != 0) begin
					bit_ch.valid  <= 1'b1;
					bit_ch.rx_bit <= rx_bit_fifo.pop_front();
					send_wait     <= draw_wait(bits_loaded);
					bits_loaded++;
				end else begin
					bit_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transaction against the oldest prediction,
	// then holds ready low for a drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		result_t     want;
		int unsigned w;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_wait    <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %b %0h %b %b %b",
						$time, res_ch.byte_valid, res_ch.data_byte, res_ch.last_of_frame,
						res_ch.sync_found, res_ch.sync_inverted);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					compare_field("byte_valid", want.byte_valid, res_ch.byte_valid);
					compare_field("data_byte", want.data_byte, res_ch.data_byte);
					compare_field("last_of_frame", want.last_of_frame, res_ch.last_of_frame);
					compare_field("sync_found", want.sync_found, res_ch.sync_found);
					compare_field("sync_inverted", want.sync_inverted, res_ch.sync_inverted);
				end
				results_seen++;
			end
			if (recv_wait != 0) begin
				recv_wait    <= recv_wait - 1;
				res_ch.ready <= (recv_wait == 1);
			end else if (res_ch.valid && res_ch.ready) begin
				w = draw_wait(results_seen);
				recv_wait    <= w;
				res_ch.ready <= (w == 0);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Hang detector: any transaction on any channel resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((bit_ch.valid && bit_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("frame_sync_derandomizer regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Queue the n low bits of v, most significant first (stream order).
	task automatic push_bits(input logic [31:0] v, input int unsigned n);
		for (int i = n - 1; i >= 0; i--) begin
			rx_bit_fifo.push_back(v[i]);
			bits_in_flight++;
			bits_queued++;
		end
	endtask

	task automatic push_random_bits(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			push_bits($urandom_range(0, 1), 1);
	endtask

	// Marker of random polarity, then payload. Frames over 12 bytes get 1 to 12
	// bytes; otherwise mostly the full frame plus up to two bytes past it (covers last
	// byte and lock drop), sometimes cut short so the next marker lands mid-frame; occasionally off a byte boundary.
	task automatic push_frame(input logic [31:0] mk, input int unsigned fb);
		int unsigned sel;
		int unsigned nbytes;
		sel = $urandom_range(0, 9);
		push_bits($urandom_range(0, 1) ? ~mk : mk, 32);
		if (fb > 12)
			nbytes = $urandom_range(1, 12);
		else if (sel < 7)
			nbytes = fb + $urandom_range(0, 2);
		else
			nbytes = $urandom_range(0, fb);
		push_random_bits(nbytes * 8 + ((sel == 9) ? $urandom_range(1, 7) : 0));
	endtask

	// Sender holds off until every bit is in and every result is out, then
	// lets the pipeline empty of bits that give no result.
	task automatic wait_drained();
		while (bits_in_flight != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_SYNC_MARKER)
			marker = val;
		else if (idx == REG_FRAME_BYTES)
			frame_len = val[7:0];
	endtask

	task automatic run_phase(input logic [31:0] mk, input logic [7:0] fb,
			input int unsigned n_bits, input bit hold_mid);
		logic [31:0] fb_word;
		int unsigned start;
		int unsigned sel;
		bit          held;
		wait_drained();
		fb_word      = $urandom();
		fb_word[7:0] = fb;   // upper bits are don't-care
		write_reg(REG_SYNC_MARKER, mk);
		write_reg(REG_FRAME_BYTES, fb_word);
		// unmapped, ignored
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_IDX_TOP)), $urandom());
		start = bits_queued;
		held  = 1'b0;
		while (bits_queued - start < n_bits) begin
			if (hold_mid && !held && (bits_queued - start) >= n_bits / 2) begin
				wait_drained();
				held = 1'b1;
			end
			sel = $urandom_range(0, 19);
			if (sel < 14)
				push_frame(mk, fb);
			else if (sel < 17)
				push_random_bits($urandom_range(1, 24));
			else
				push_bits(mk ^ (32'h1 << $urandom_range(0, 31)), 32);   // one bit off
			// let the driver take the bits before queueing more
			while (rx_bit_fifo.size() > 64)
				@(posedge clk);
		end
	endtask

	initial begin
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data  <= '0;
		@(posedge arst_n);

		// Directed, reset config: noise, marker, bytes, inverted marker right on a
		// byte boundary (byte and sync in one result), more bytes, a near-miss marker.
		push_bits(32'hA5, 8);
		push_bits(SYNC_MARKER_RST, 32);
		push_bits(32'h00FF5A, 24);
		push_bits(~SYNC_MARKER_RST, 32);
		push_bits(32'hFF00, 16);
		push_bits(SYNC_MARKER_RST ^ 32'h1, 32);

		// Shortest frame, zero length, all-zero marker (with a mid-phase hold-off),
		// all-ones marker with the longest frame, then random settings.
		run_phase(SYNC_MARKER_RST, 8'd1, 110, 1'b0);
		run_phase($urandom(), 8'd0, 80, 1'b0);
		run_phase(32'h0000_0000, 8'd3, 110, 1'b1);
		run_phase(32'hFFFF_FFFF, 8'd255, 110, 1'b0);
		run_phase($urandom(), 8'($urandom_range(1, 6)), 120, 1'b0);
		run_phase($urandom(), 8'd2, 100, 1'b0);

		wait_drained();
		if (mismatches == 0 && results_due.size() == 0)
			$display("frame_sync_derandomizer regression: pass");
		else
			$display("frame_sync_derandomizer regression: fail");
		$finish;
	end

endmodule
